/* src/tsq_pkg.sv */
// Shared constants and types for the two-stack queue.
package tsq_pkg;

	localparam int DEPTH = 128;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(2 * DEPTH);
	localparam int DW = 32;

	localparam logic [7:0] DEPTH_RESET = 8'd128;

	localparam logic [1:0] ACT_PUSH = 2'd0;
	localparam logic [1:0] ACT_POP  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	typedef logic [CW-1:0] cnt_t;
	typedef logic [AW-1:0] ptr_t;

endpackage

/* src/tsq_ram.sv */
// Simple dual-port RAM with a registered read port.
module tsq_ram #(
	parameter int AW = 8,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/two_stack_queue_top.sv */
// Top level of the two-stack queue.
//
// The queue keeps every word in one ring memory in age order, so the move of the
// input stack into the output stack is only a change of the two counts. The
// memory access is issued when the word is accepted; the read data is registered
// in the RAM read port and then loaded into the output register. A new word is
// not accepted while the last one is still in flight or a result word is stalled.
module two_stack_queue_top import tsq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value[31:0], index[39:32]
	input  logic [1:0]  s_tuser,   // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // data[31:0], count[40:32], full_res[41], zero[47:42]
	output logic [0:0]  m_tuser,   // error[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	logic [7:0] depth_q;
	cnt_t       eff;
	cnt_t       ic_q, oc_q, ic_n, oc_n;
	ptr_t       head_q, head_n;
	logic [CW:0] total;
	logic       afull;
	logic       accept;
	logic [1:0] act;
	logic [7:0] idx;
	logic       err_n, re_n, we_n;
	ptr_t       raddr, waddr;
	logic [DW-1:0] rdata;

	logic       busy_s1, rd_s1, err_s1, full_s1;
	logic [8:0] count_s1;

	logic          out_valid_q, out_err_q, out_full_q;
	logic [DW-1:0] out_data_q;
	logic [8:0]    out_count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
		end else if (cfg_valid) begin
			depth_q <= cfg_data;
		end
	end

	always_comb begin
		if (depth_q == 8'd0) begin
			eff = CW'(1);
		end else if (32'(depth_q) > DEPTH) begin
			eff = CW'(DEPTH);
		end else begin
			eff = CW'(depth_q);
		end
	end

	assign act    = s_tuser;
	assign idx    = s_tdata[39:32];
	assign total  = {1'b0, oc_q} + {1'b0, ic_q};
	assign afull  = ic_q >= eff;
	assign s_tready = !busy_s1 && (!out_valid_q || m_tready);
	assign accept = s_tvalid && s_tready;

	always_comb begin
		oc_n   = oc_q;
		ic_n   = ic_q;
		head_n = head_q;
		err_n  = 1'b0;
		re_n   = 1'b0;
		we_n   = 1'b0;
		raddr  = head_q;
		waddr  = head_q + AW'(total);
		unique case (act)
			ACT_PUSH: begin
				if (afull && oc_q != '0) begin
					err_n = 1'b1;
				end else begin
					if (afull) begin
						oc_n = ic_q;
						ic_n = '0;
					end
					we_n = 1'b1;
					ic_n = ic_n + CW'(1);
				end
			end
			ACT_POP: begin
				if (total != '0) begin
					re_n   = 1'b1;
					head_n = head_q + AW'(1);
					if (oc_q != '0) begin
						oc_n = oc_q - CW'(1);
					end else begin
						ic_n = ic_q - CW'(1);
					end
				end else begin
					err_n = 1'b1;
				end
			end
			ACT_READ: begin
				if (32'(idx) >= 32'(total)) begin
					err_n = 1'b1;
				end else begin
					re_n  = 1'b1;
					raddr = head_q + AW'(idx);
				end
			end
			default: begin
				err_n = 1'b1;
			end
		endcase
	end

	tsq_ram #(.AW(AW), .DW(DW)) u_ram (
		.clk   (clk),
		.we    (accept && we_n),
		.waddr (waddr),
		.wdata (s_tdata[31:0]),
		.re    (accept && re_n),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_q    <= '0;
			ic_q    <= '0;
			head_q  <= '0;
			busy_s1 <= 1'b0;
		end else begin
			busy_s1 <= accept;
			if (accept) begin
				oc_q   <= oc_n;
				ic_q   <= ic_n;
				head_q <= head_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1    <= re_n;
			err_s1   <= err_n;
			count_s1 <= 9'({1'b0, oc_n} + {1'b0, ic_n});
			full_s1  <= (oc_n != '0) && (ic_n >= eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (busy_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_s1) begin
			out_data_q  <= rd_s1 ? rdata : '0;
			out_err_q   <= err_s1;
			out_count_q <= count_s1;
			out_full_q  <= full_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_full_q, out_count_q, out_data_q};
	assign m_tuser  = out_err_q;

endmodule

/* src/tsq_checker.sv */
// Port-level checks for the two-stack queue, bound to the top level.
module tsq_checker import tsq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [0:0]  m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Stalled result word changed.");

	a_two_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Input word accepted on consecutive cycles.");

	a_result_due: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("Accepted word produced no result word.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'd0)
		else $error("Error result carries nonzero data.");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(m_tdata[40:32]) <= 2 * DEPTH)
		else $error("Result count exceeds queue capacity.");

endmodule

bind two_stack_queue_top tsq_checker u_tsq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
